@@ rtl/core/sfxm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxm_pkg: shared definitions of the two-voice playback mixer
// Command and register codes, job queue entry type, fixed widths and gain.
// ----------------------------------------------------------------------------
package sfxm_pkg;

    // Default sizes of the clip stores
    localparam int LONG_CLIP_SAMPLES_DEF = 262144;
    localparam int SHORT_CLIP_FRAMES_DEF = 16384;
    localparam int SHORT_CLIP_COUNT_DEF  = 3;

    // Phase format: Q24.16 accumulator, Q8.16 step
    localparam int PHASE_W = 40;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = 24;

    // Word address fields sized for the largest allowed clip stores
    localparam int LONG_WORD_W  = 19;
    localparam int SHORT_WORD_W = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Long voice gain, 0.85 in Q1.15 truncated
    localparam logic signed [15:0] GAIN_Q15 = 16'sd27852;

    // Item commands
    localparam logic [2:0] CMD_MIX         = 3'd0;
    localparam logic [2:0] CMD_START_LONG  = 3'd1;
    localparam logic [2:0] CMD_START_SHORT = 3'd2;
    localparam logic [2:0] CMD_WRITE_LONG  = 3'd3;
    localparam logic [2:0] CMD_WRITE_SHORT = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_LONG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_LONG_STEP     = 3'd1;
    localparam logic [2:0] REG_SHORT_STEP    = 3'd2;
    localparam logic [2:0] REG_LONG_FRAMES   = 3'd3;
    localparam logic [2:0] REG_SHORT0_FRAMES = 3'd4;
    localparam logic [2:0] REG_SHORT1_FRAMES = 3'd5;
    localparam logic [2:0] REG_SHORT2_FRAMES = 3'd6;

    // Job kinds handed from front to back
    localparam logic [1:0] JOB_MIX      = 2'd0;
    localparam logic [1:0] JOB_WR_LONG  = 2'd1;
    localparam logic [1:0] JOB_WR_SHORT = 2'd2;

    // One queue entry: a mix with its read plan, or a clip store write
    typedef struct packed {
        logic [1:0]              kind;
        logic signed [15:0]      in_left;
        logic signed [15:0]      in_right;
        logic [LONG_WORD_W-1:0]  long_word;
        logic                    long_lsel;
        logic                    long_rsel;
        logic                    long_lok;
        logic                    long_rok;
        logic                    wr_bank;
        logic [15:0]             wr_data;
        logic                    short_ok;
        logic [1:0]              short_sel;
        logic [SHORT_WORD_W-1:0] short_word;
        logic                    long_active;
        logic                    short_active;
    } sfxm_job_t;

endpackage

@@ rtl/core/sfxm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxm_if: channel interfaces of the playback mixer
// Command item channel, mix result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Command items
interface sfxm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] in_left;
    logic [15:0] in_right;
    logic [1:0]  clip_select;
    logic [17:0] sample_addr;
    logic [15:0] sample_value;

    modport source (output valid, cmd, in_left, in_right, clip_select, sample_addr,
                    sample_value, input ready);
    modport sink (input valid, cmd, in_left, in_right, clip_select, sample_addr,
                  sample_value, output ready);
endinterface

// Mixed frames
interface sfxm_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_left;
    logic [15:0] out_right;
    logic        long_active;
    logic        short_active;

    modport source (output valid, out_left, out_right, long_active, short_active,
                    input ready);
    modport sink (input valid, out_left, out_right, long_active, short_active,
                  output ready);
endinterface

// Register writes
interface sfxm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/sfxm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfxm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sfxm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxm_front: command decode and voice sequencing
// Holds the registers and both voice phases, decodes each item, advances the
// voices on mix items and queues a job (read plan or clip write) for the back.
// ----------------------------------------------------------------------------
module sfxm_front import sfxm_pkg::*; #(
    parameter int LONG_CLIP_SAMPLES = LONG_CLIP_SAMPLES_DEF,
    parameter int SHORT_CLIP_FRAMES = SHORT_CLIP_FRAMES_DEF,
    parameter int SHORT_CLIP_COUNT  = SHORT_CLIP_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sfxm_req_if.sink   req,
    sfxm_cfg_if.sink   cfg,
    output logic       push,
    output sfxm_job_t  job,
    input  logic       full
);

    localparam logic [20:0] LONG_LIM        = 21'(LONG_CLIP_SAMPLES);
    localparam logic [18:0] SHORT_WR_LIM    = 19'(2 * SHORT_CLIP_FRAMES);
    localparam logic [23:0] SHORT_FRAME_LIM = 24'(SHORT_CLIP_FRAMES);
    localparam logic [2:0]  CLIP_LIM        = 3'(SHORT_CLIP_COUNT);

    // Configuration registers
    logic [1:0]        chan_reg;
    logic [STEP_W-1:0] lstep_reg;
    logic [STEP_W-1:0] sstep_reg;
    logic [18:0]       lframes_reg;
    logic [2:0][14:0]  sframes_reg;

    // Voice state
    logic [PHASE_W-1:0] long_phase_reg, long_phase_next;
    logic [PHASE_W-1:0] short_phase_reg, short_phase_next;
    logic               long_playing_reg, long_playing_next;
    logic               short_playing_reg, short_playing_next;
    logic [1:0]         short_sel_reg, short_sel_next;

    logic        acc;
    logic        long_ok, l_end, long_use, stereo;
    logic [23:0] l_frame;
    logic [18:0] f19;
    logic [20:0] even_idx, odd_idx, mono_idx;
    logic [14:0] slen_cur, slen_req;
    logic        short_ok, s_end, short_use;
    logic [23:0] s_frame;
    logic        clip_ok;

    // Frame count of a short clip, zero past the clip count
    function automatic logic [14:0] pick_len(input logic [1:0] s, input logic [2:0][14:0] f);
        logic [14:0] r;
        r = '0;
        if ({1'b0, s} < CLIP_LIM)
        begin
            case (s)
                2'd0:    r = f[0];
                2'd1:    r = f[1];
                2'd2:    r = f[2];
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    assign req.ready = !full;
    assign cfg.ready = 1'b1;
    assign acc       = req.valid && req.ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg    <= 2'd2;
            lstep_reg   <= 24'd65536;
            sstep_reg   <= 24'd65536;
            lframes_reg <= '0;
            sframes_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LONG_CHANNELS: chan_reg       <= cfg.data[1:0];
                REG_LONG_STEP:     lstep_reg      <= cfg.data;
                REG_SHORT_STEP:    sstep_reg      <= cfg.data;
                REG_LONG_FRAMES:   lframes_reg    <= cfg.data[18:0];
                REG_SHORT0_FRAMES: sframes_reg[0] <= cfg.data[14:0];
                REG_SHORT1_FRAMES: sframes_reg[1] <= cfg.data[14:0];
                REG_SHORT2_FRAMES: sframes_reg[2] <= cfg.data[14:0];
                default:           ;
            endcase
        end
    end

    // Voice conditions for the current state
    always_comb
    begin
        long_ok  = long_playing_reg && (lframes_reg != '0) && (chan_reg != 2'd0);
        l_frame  = long_phase_reg[PHASE_W-1:FRAC_W];
        l_end    = l_frame >= {5'b0, lframes_reg};
        long_use = long_ok && !l_end;
        stereo   = chan_reg[1];
        f19      = l_frame[18:0];
        even_idx = {1'b0, f19, 1'b0};
        odd_idx  = {1'b0, f19, 1'b1};
        mono_idx = {2'b0, f19};

        slen_cur  = pick_len(short_sel_reg, sframes_reg);
        slen_req  = pick_len(req.clip_select, sframes_reg);
        short_ok  = short_playing_reg && (slen_cur != '0);
        s_frame   = short_phase_reg[PHASE_W-1:FRAC_W];
        s_end     = s_frame >= {9'b0, slen_cur};
        short_use = short_ok && !s_end;
        clip_ok   = {1'b0, req.clip_select} < CLIP_LIM;
    end

    // Item decode, voice update and job build
    always_comb
    begin
        long_phase_next    = long_phase_reg;
        short_phase_next   = short_phase_reg;
        long_playing_next  = long_playing_reg;
        short_playing_next = short_playing_reg;
        short_sel_next     = short_sel_reg;
        push               = 1'b0;
        job                = '0;
        job.in_left        = req.in_left;
        job.in_right       = req.in_right;
        job.wr_data        = req.sample_value;
        if (acc)
        begin
            unique case (req.cmd)
                CMD_MIX:
                begin
                    push     = 1'b1;
                    job.kind = JOB_MIX;
                    // long voice
                    if (long_ok)
                    begin
                        if (l_end)
                        begin
                            long_playing_next = 1'b0;
                            long_phase_next   = '0;
                        end
                        else
                        begin
                            long_phase_next = long_phase_reg + PHASE_W'(lstep_reg);
                        end
                    end
                    job.long_word = stereo ? f19 : {1'b0, f19[18:1]};
                    job.long_lsel = stereo ? 1'b0 : f19[0];
                    job.long_rsel = stereo ? 1'b1 : f19[0];
                    job.long_lok  = long_use && (stereo ? (even_idx < LONG_LIM)
                                                        : (mono_idx < LONG_LIM));
                    job.long_rok  = long_use && (stereo ? (odd_idx < LONG_LIM)
                                                        : (mono_idx < LONG_LIM));
                    // short voice
                    if (short_ok)
                    begin
                        if (s_end)
                        begin
                            short_playing_next = 1'b0;
                            short_phase_next   = '0;
                        end
                        else
                        begin
                            short_phase_next = short_phase_reg + PHASE_W'(sstep_reg);
                        end
                    end
                    job.short_ok     = short_use && (s_frame < SHORT_FRAME_LIM);
                    job.short_sel    = short_sel_reg;
                    job.short_word   = s_frame[SHORT_WORD_W-1:0];
                    job.long_active  = long_playing_next;
                    job.short_active = short_playing_next;
                end
                CMD_START_LONG:
                begin
                    if ((lframes_reg != '0) && (chan_reg != 2'd0))
                    begin
                        long_phase_next   = '0;
                        long_playing_next = 1'b1;
                    end
                end
                CMD_START_SHORT:
                begin
                    if (slen_req != '0)
                    begin
                        short_phase_next   = '0;
                        short_playing_next = 1'b1;
                        short_sel_next     = req.clip_select;
                    end
                end
                CMD_WRITE_LONG:
                begin
                    if ({3'b0, req.sample_addr} < LONG_LIM)
                    begin
                        push          = 1'b1;
                        job.kind      = JOB_WR_LONG;
                        job.long_word = {2'b0, req.sample_addr[17:1]};
                        job.wr_bank   = req.sample_addr[0];
                    end
                end
                CMD_WRITE_SHORT:
                begin
                    if (clip_ok && ({1'b0, req.sample_addr} < SHORT_WR_LIM))
                    begin
                        push           = 1'b1;
                        job.kind       = JOB_WR_SHORT;
                        job.short_sel  = req.clip_select;
                        job.short_word = req.sample_addr[SHORT_WORD_W:1];
                        job.wr_bank    = req.sample_addr[0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Voice state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_phase_reg    <= '0;
            short_phase_reg   <= '0;
            long_playing_reg  <= 1'b0;
            short_playing_reg <= 1'b0;
            short_sel_reg     <= '0;
        end
        else
        begin
            long_phase_reg    <= long_phase_next;
            short_phase_reg   <= short_phase_next;
            long_playing_reg  <= long_playing_next;
            short_playing_reg <= short_playing_next;
            short_sel_reg     <= short_sel_next;
        end
    end

    // A long voice that runs off its clip stops with its phase cleared
    a_long_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.cmd == CMD_MIX) && long_ok && l_end)
        |=> (!long_playing_reg && (long_phase_reg == '0)))
        else $error("long voice did not stop at clip end");

    // Starting an empty long clip leaves the voice untouched
    a_empty_start: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.cmd == CMD_START_LONG) && (lframes_reg == '0))
        |=> ($stable(long_playing_reg) && $stable(long_phase_reg)))
        else $error("empty long clip start changed the voice");

    // Only accepted mix and write items enter the queue
    a_push_kind: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (acc && ((req.cmd == CMD_MIX) || (req.cmd == CMD_WRITE_LONG)
                          || (req.cmd == CMD_WRITE_SHORT))))
        else $error("job queued for an item that needs none");

endmodule

@@ rtl/core/sfxm_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxm_fifo: job queue between front and back
// Small register queue so that decode and playback can stall independently.
// ----------------------------------------------------------------------------
module sfxm_fifo import sfxm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sfxm_job_t push_job,
    output logic      full,
    input  logic      pop,
    output sfxm_job_t pop_job,
    output logic      empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    sfxm_job_t     slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = count_reg == CNT_FULL;
    assign empty   = count_reg == '0;
    assign pop_job = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("job popped from an empty queue");

endmodule

@@ rtl/core/sfxm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxm_back: clip stores and mix pipeline
// Executes queued jobs: clip writes, sample reads, long voice gain, summing
// with saturation, and the result register. All stages advance together.
// ----------------------------------------------------------------------------
module sfxm_back import sfxm_pkg::*; #(
    parameter int LONG_CLIP_SAMPLES = LONG_CLIP_SAMPLES_DEF,
    parameter int SHORT_CLIP_FRAMES = SHORT_CLIP_FRAMES_DEF,
    parameter int SHORT_CLIP_COUNT  = SHORT_CLIP_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  sfxm_job_t   pop_job,
    input  logic        empty,
    output logic        pop,
    sfxm_rsp_if.source  rsp
);

    localparam int LHALF = (LONG_CLIP_SAMPLES + 1) / 2;
    localparam int LA_W  = $clog2(LHALF);
    localparam int SW    = $clog2(SHORT_CLIP_FRAMES);

    logic advance;
    logic wr_long, wr_short;

    // Stage B: job with read data returning
    logic      b_valid_reg;
    sfxm_job_t b_job_reg;
    logic [15:0] long_even_data, long_odd_data;
    logic [15:0] sh_even_data [SHORT_CLIP_COUNT];
    logic [15:0] sh_odd_data  [SHORT_CLIP_COUNT];
    logic signed [15:0] l_samp, r_samp, sh_l, sh_r;
    logic signed [31:0] prod_l, prod_r;

    // Stage C: products and short samples
    logic               c_valid_reg;
    logic signed [31:0] c_prod_l_reg, c_prod_r_reg;
    logic signed [15:0] c_sh_l_reg, c_sh_r_reg;
    logic signed [15:0] c_in_l_reg, c_in_r_reg;
    logic               c_lact_reg, c_sact_reg;
    logic signed [31:0] rnd_l, rnd_r;
    logic signed [17:0] sum_l, sum_r;
    logic signed [15:0] sat_l, sat_r;

    // Result register
    logic        rsp_valid_reg;
    logic [15:0] out_l_reg, out_r_reg;
    logic        lact_reg, sact_reg;

    assign advance  = !rsp_valid_reg || rsp.ready;
    assign pop      = advance && !empty;
    assign wr_long  = pop && (pop_job.kind == JOB_WR_LONG);
    assign wr_short = pop && (pop_job.kind == JOB_WR_SHORT);

    // Long clip store, split into even and odd sample banks
    sfxm_ram #(.WIDTH(16), .DEPTH(LHALF)) u_long_even (
        .clk   (clk),
        .we    (wr_long && !pop_job.wr_bank),
        .waddr (pop_job.long_word[LA_W-1:0]),
        .wdata (pop_job.wr_data),
        .re    (advance),
        .raddr (pop_job.long_word[LA_W-1:0]),
        .rdata (long_even_data)
    );

    sfxm_ram #(.WIDTH(16), .DEPTH(LHALF)) u_long_odd (
        .clk   (clk),
        .we    (wr_long && pop_job.wr_bank),
        .waddr (pop_job.long_word[LA_W-1:0]),
        .wdata (pop_job.wr_data),
        .re    (advance),
        .raddr (pop_job.long_word[LA_W-1:0]),
        .rdata (long_odd_data)
    );

    // Short clip stores, left and right banks per clip
    for (genvar c = 0; c < SHORT_CLIP_COUNT; c++)
    begin : g_short
        logic sel_hit;
        assign sel_hit = pop_job.short_sel == 2'(c);

        sfxm_ram #(.WIDTH(16), .DEPTH(SHORT_CLIP_FRAMES)) u_even (
            .clk   (clk),
            .we    (wr_short && sel_hit && !pop_job.wr_bank),
            .waddr (pop_job.short_word[SW-1:0]),
            .wdata (pop_job.wr_data),
            .re    (advance),
            .raddr (pop_job.short_word[SW-1:0]),
            .rdata (sh_even_data[c])
        );

        sfxm_ram #(.WIDTH(16), .DEPTH(SHORT_CLIP_FRAMES)) u_odd (
            .clk   (clk),
            .we    (wr_short && sel_hit && pop_job.wr_bank),
            .waddr (pop_job.short_word[SW-1:0]),
            .wdata (pop_job.wr_data),
            .re    (advance),
            .raddr (pop_job.short_word[SW-1:0]),
            .rdata (sh_odd_data[c])
        );
    end

    // Stage B: pick samples, scale the long voice
    always_comb
    begin
        l_samp = '0;
        r_samp = '0;
        if (b_job_reg.long_lok)
        begin
            l_samp = $signed(b_job_reg.long_lsel ? long_odd_data : long_even_data);
        end
        if (b_job_reg.long_rok)
        begin
            r_samp = $signed(b_job_reg.long_rsel ? long_odd_data : long_even_data);
        end
        sh_l = '0;
        sh_r = '0;
        for (int c = 0; c < SHORT_CLIP_COUNT; c++)
        begin
            if (b_job_reg.short_ok && (b_job_reg.short_sel == 2'(c)))
            begin
                sh_l = $signed(sh_even_data[c]);
                sh_r = $signed(sh_odd_data[c]);
            end
        end
        prod_l = l_samp * GAIN_Q15;
        prod_r = r_samp * GAIN_Q15;
    end

    // Stage C: divide by 32768 toward zero, sum and clamp
    always_comb
    begin
        rnd_l = c_prod_l_reg + (c_prod_l_reg[31] ? 32'sd32767 : 32'sd0);
        rnd_r = c_prod_r_reg + (c_prod_r_reg[31] ? 32'sd32767 : 32'sd0);
        sum_l = 18'(c_in_l_reg) + 18'($signed(rnd_l[30:15])) + 18'(c_sh_l_reg);
        sum_r = 18'(c_in_r_reg) + 18'($signed(rnd_r[30:15])) + 18'(c_sh_r_reg);
        if (sum_l > 18'sd32767)
        begin
            sat_l = 16'sh7FFF;
        end
        else if (sum_l < -18'sd32768)
        begin
            sat_l = 16'sh8000;
        end
        else
        begin
            sat_l = sum_l[15:0];
        end
        if (sum_r > 18'sd32767)
        begin
            sat_r = 16'sh7FFF;
        end
        else if (sum_r < -18'sd32768)
        begin
            sat_r = 16'sh8000;
        end
        else
        begin
            sat_r = sum_r[15:0];
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg   <= pop && (pop_job.kind == JOB_MIX);
            c_valid_reg   <= b_valid_reg;
            rsp_valid_reg <= c_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_job_reg    <= pop_job;
            c_prod_l_reg <= prod_l;
            c_prod_r_reg <= prod_r;
            c_sh_l_reg   <= sh_l;
            c_sh_r_reg   <= sh_r;
            c_in_l_reg   <= b_job_reg.in_left;
            c_in_r_reg   <= b_job_reg.in_right;
            c_lact_reg   <= b_job_reg.long_active;
            c_sact_reg   <= b_job_reg.short_active;
            out_l_reg    <= sat_l;
            out_r_reg    <= sat_r;
            lact_reg     <= c_lact_reg;
            sact_reg     <= c_sact_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.out_left     = out_l_reg;
    assign rsp.out_right    = out_r_reg;
    assign rsp.long_active  = lact_reg;
    assign rsp.short_active = sact_reg;

    // A stalled result freezes the whole pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> ($stable(c_valid_reg) && $stable(b_valid_reg)))
        else $error("pipeline moved while result stalled");

endmodule

@@ rtl/core/two_voice_sfx_playback_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_voice_sfx_playback_mixer: two-voice clip playback mixer, stereo 16 bit
// Mixes a long clip voice (gain 0.85) and a short clip voice onto a stream.
// ----------------------------------------------------------------------------
// Usage:
//   req  carries command items: mix a frame, start the long clip, start a short
//        clip, or write one sample into a clip store.
//   rsp  returns one mixed, saturated frame per mix item, with the activity
//        flags of both voices; other commands return nothing.
//   cfg  writes the step, length and channel registers; it is always ready.
//        The user must write it only while no item is in flight (unchecked).
// Timing: one item per cycle while the job queue is not full. A mix result
//   passes the queue, clip store read, gain multiply and sum and clamp, each
//   registered. The phase update in the front sets the item rate.
// Stall: when rsp is held, the back pipeline freezes; the front keeps taking
//   items into a 4-entry job queue and drops req.ready when it is full.
// Reset: voices stop with phases cleared, registers take their defaults. Clip
//   stores are not cleared and hold no data until written.
// ----------------------------------------------------------------------------
module two_voice_sfx_playback_mixer import sfxm_pkg::*; #(
    parameter int LONG_CLIP_SAMPLES = LONG_CLIP_SAMPLES_DEF,
    parameter int SHORT_CLIP_FRAMES = SHORT_CLIP_FRAMES_DEF,
    parameter int SHORT_CLIP_COUNT  = SHORT_CLIP_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sfxm_req_if.sink   req,
    sfxm_rsp_if.source rsp,
    sfxm_cfg_if.sink   cfg
);

    logic      push, pop, full, empty;
    sfxm_job_t push_job, pop_job;

    // Decode and voice sequencing
    sfxm_front #(
        .LONG_CLIP_SAMPLES (LONG_CLIP_SAMPLES),
        .SHORT_CLIP_FRAMES (SHORT_CLIP_FRAMES),
        .SHORT_CLIP_COUNT  (SHORT_CLIP_COUNT)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .push  (push),
        .job   (push_job),
        .full  (full)
    );

    // Job queue
    sfxm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    // Clip stores and mix pipeline
    sfxm_back #(
        .LONG_CLIP_SAMPLES (LONG_CLIP_SAMPLES),
        .SHORT_CLIP_FRAMES (SHORT_CLIP_FRAMES),
        .SHORT_CLIP_COUNT  (SHORT_CLIP_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop_job (pop_job),
        .empty   (empty),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

@@ tb/tb_two_voice_sfx_playback_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_voice_sfx_playback_mixer: self-checking bench of the playback mixer
// Drives command items, register writes and result back-pressure at random,
// predicts every mixed frame with its own voice model and checks each result
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_two_voice_sfx_playback_mixer;
    import sfxm_pkg::*;

    localparam int SHORT_WORDS   = 2 * SHORT_CLIP_FRAMES_DEF;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 16;
    localparam int FAR_MIXES     = 72;
    localparam int TIMEOUT_NS    = 400000;

    // One command item as offered on req
    typedef struct {
        logic [2:0]         cmd;
        logic signed [15:0] in_left;
        logic signed [15:0] in_right;
        logic [1:0]         clip_select;
        logic [17:0]        sample_addr;
        logic [15:0]        sample_value;
    } mix_cmd_t;

    // One mixed frame as returned on rsp
    typedef struct {
        logic [15:0] out_left;
        logic [15:0] out_right;
        logic        long_active;
        logic        short_active;
    } mixed_frame_t;

    // ------------------------------------------------------------------------
    // Voice model and frame scoreboard
    // ------------------------------------------------------------------------
    class mixer_scoreboard;
        logic [39:0]  long_phase;
        logic [39:0]  short_phase;
        bit           long_playing;
        bit           short_playing;
        logic [1:0]   short_selected;
        logic [1:0]   long_channels;
        logic [23:0]  long_step;
        logic [23:0]  short_step;
        logic [18:0]  long_frames;
        logic [14:0]  short_frames [3];
        logic [15:0]  long_mem [int];
        logic [15:0]  short_mem [int];
        mixed_frame_t expected_frames [$];
        int           mismatches;

        function new();
            long_phase     = '0;
            short_phase    = '0;
            long_playing   = 1'b0;
            short_playing  = 1'b0;
            short_selected = 2'd0;
            long_channels  = 2'd2;
            long_step      = 24'h010000;
            short_step     = 24'h010000;
            long_frames    = '0;
            short_frames[0] = '0;
            short_frames[1] = '0;
            short_frames[2] = '0;
            mismatches     = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void set_reg(logic [2:0] index, logic [23:0] data);
            case (index)
                REG_LONG_CHANNELS: long_channels   = data[1:0];
                REG_LONG_STEP:     long_step       = data;
                REG_SHORT_STEP:    short_step      = data;
                REG_LONG_FRAMES:   long_frames     = data[18:0];
                REG_SHORT0_FRAMES: short_frames[0] = data[14:0];
                REG_SHORT1_FRAMES: short_frames[1] = data[14:0];
                REG_SHORT2_FRAMES: short_frames[2] = data[14:0];
                default: ;
            endcase
        endfunction

        function bit long_usable();
            return (long_frames != 0) && (long_channels != 0);
        endfunction

        function logic [14:0] short_length(logic [1:0] sel);
            if (sel >= SHORT_CLIP_COUNT_DEF)
                return '0;
            return short_frames[sel];
        endfunction

        // Past the end of the store the long clip reads as silence
        function int long_sample(int idx);
            if (idx >= LONG_CLIP_SAMPLES_DEF || !long_mem.exists(idx))
                return 0;
            return int'($signed(long_mem[idx]));
        endfunction

        function int short_sample(int key);
            if (!short_mem.exists(key))
                return 0;
            return int'($signed(short_mem[key]));
        endfunction

        function logic [15:0] clamp16(int v);
            if (v < -32768)
                return 16'h8000;
            if (v > 32767)
                return 16'h7FFF;
            return v[15:0];
        endfunction

        // Next long store word the coming mix reads that was never written
        function bit missing_long(output int addr);
            logic [23:0] frame;
            int          n;
            int          k;
            int          idx;
            addr = 0;
            if (!long_playing || !long_usable())
                return 1'b0;
            frame = long_phase[39:16];
            if (frame >= long_frames)
                return 1'b0;
            n = (long_channels >= 2) ? 2 : 1;
            for (k = 0; k < n; k++)
            begin
                idx = frame * n + k;
                if (idx < LONG_CLIP_SAMPLES_DEF && !long_mem.exists(idx))
                begin
                    addr = idx;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Same for the selected short clip
        function bit missing_short(output logic [1:0] sel, output int addr);
            logic [23:0] frame;
            logic [14:0] slen;
            int          k;
            int          key;
            sel  = short_selected;
            addr = 0;
            slen = short_length(short_selected);
            if (!short_playing || slen == 0)
                return 1'b0;
            frame = short_phase[39:16];
            if (frame >= slen || frame >= SHORT_CLIP_FRAMES_DEF)
                return 1'b0;
            for (k = 0; k < 2; k++)
            begin
                key = short_selected * SHORT_WORDS + frame * 2 + k;
                if (!short_mem.exists(key))
                begin
                    addr = frame * 2 + k;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Advance both voices by one output frame and form the mix
        function mixed_frame_t predict_mix(mix_cmd_t item);
            mixed_frame_t res;
            int           left;
            int           right;
            int           l;
            int           r;
            int           base;
            logic [23:0]  frame;
            logic [14:0]  slen;
            left  = int'(item.in_left);
            right = int'(item.in_right);

            if (long_playing && long_usable())
            begin
                frame = long_phase[39:16];
                if (frame >= long_frames)
                begin
                    long_playing = 1'b0;
                    long_phase   = '0;
                end
                else
                begin
                    if (long_channels >= 2)
                    begin
                        l = long_sample(frame * 2);
                        r = long_sample(frame * 2 + 1);
                    end
                    else
                    begin
                        l = long_sample(frame);
                        r = l;
                    end
                    // signed division truncates toward zero
                    left  += (l * int'(GAIN_Q15)) / 32768;
                    right += (r * int'(GAIN_Q15)) / 32768;
                    long_phase = long_phase + long_step;
                end
            end

            slen = short_length(short_selected);
            if (short_playing && slen != 0)
            begin
                frame = short_phase[39:16];
                if (frame >= slen)
                begin
                    short_playing = 1'b0;
                    short_phase   = '0;
                end
                else
                begin
                    // frames beyond the store add nothing
                    if (frame < SHORT_CLIP_FRAMES_DEF)
                    begin
                        base   = short_selected * SHORT_WORDS + frame * 2;
                        left  += short_sample(base);
                        right += short_sample(base + 1);
                    end
                    short_phase = short_phase + short_step;
                end
            end

            res.out_left     = clamp16(left);
            res.out_right    = clamp16(right);
            res.long_active  = long_playing;
            res.short_active = short_playing;
            return res;
        endfunction

        function void note_accepted(mix_cmd_t item);
            case (item.cmd)
                CMD_MIX:
                    expected_frames.push_back(predict_mix(item));
                CMD_START_LONG:
                    if (long_usable())
                    begin
                        long_phase   = '0;
                        long_playing = 1'b1;
                    end
                CMD_START_SHORT:
                    if (short_length(item.clip_select) != 0)
                    begin
                        short_phase    = '0;
                        short_playing  = 1'b1;
                        short_selected = item.clip_select;
                    end
                CMD_WRITE_LONG:
                    long_mem[int'(item.sample_addr)] = item.sample_value;
                CMD_WRITE_SHORT:
                    if (item.clip_select < SHORT_CLIP_COUNT_DEF &&
                        item.sample_addr < SHORT_WORDS)
                        short_mem[item.clip_select * SHORT_WORDS + item.sample_addr] =
                            item.sample_value;
                default: ;
            endcase
        endfunction

        function void check_frame(mixed_frame_t got);
            mixed_frame_t want;
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame: L=%0d R=%0d long=%0b short=%0b",
                             $signed(got.out_left), $signed(got.out_right),
                             got.long_active, got.short_active);
                return;
            end
            want = expected_frames.pop_front();
            if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
                got.long_active !== want.long_active || got.short_active !== want.short_active)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("frame differs: exp %0d %0d %0b %0b, got %0d %0d %0b %0b",
                             $signed(want.out_left), $signed(want.out_right),
                             want.long_active, want.short_active,
                             $signed(got.out_left), $signed(got.out_right),
                             got.long_active, got.short_active);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    bit   hold_ask;
    bit   sender_may_idle;
    int   items_sent;

    mixer_scoreboard sb = new();

    sfxm_req_if req_ch ();
    sfxm_rsp_if rsp_ch ();
    sfxm_cfg_if cfg_ch ();

    two_voice_sfx_playback_mixer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, one stall-free stretch
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int seen;
        bit held;
        hold_left = 0;
        seen      = 0;
        held      = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready)
                seen++;
            if (hold_ask && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (seen >= 100 && seen < 250)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 9);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        mixed_frame_t got;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
        begin
            got.out_left     = rsp_ch.out_left;
            got.out_right    = rsp_ch.out_right;
            got.long_active  = rsp_ch.long_active;
            got.short_active = rsp_ch.short_active;
            sb.check_frame(got);
        end
    end

    // ------------------------------------------------------------------------
    // Item drivers
    // ------------------------------------------------------------------------
    function automatic logic [15:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 16'h7FFF;
        if (r < 10)
            return 16'h8000;
        if (r < 13)
            return 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic send_item(input logic [2:0] cmd, input logic [15:0] left,
                             input logic [15:0] right, input logic [1:0] sel,
                             input logic [17:0] addr, input logic [15:0] val);
        mix_cmd_t item;
        while (sender_may_idle && $urandom_range(99) < 9)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= cmd;
        req_ch.in_left      <= left;
        req_ch.in_right     <= right;
        req_ch.clip_select  <= sel;
        req_ch.sample_addr  <= addr;
        req_ch.sample_value <= val;
        item.cmd          = cmd;
        item.in_left      = left;
        item.in_right     = right;
        item.clip_select  = sel;
        item.sample_addr  = addr;
        item.sample_value = val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_accepted(item);
    endtask

    task automatic start_long();
        send_item(CMD_START_LONG, 16'($urandom), 16'($urandom), 2'($urandom),
                  18'($urandom), 16'($urandom));
        items_sent++;
    endtask

    task automatic start_short(input logic [1:0] sel);
        send_item(CMD_START_SHORT, 16'($urandom), 16'($urandom), sel, 18'($urandom),
                  16'($urandom));
        items_sent++;
    endtask

    task automatic write_long(input logic [17:0] addr, input logic [15:0] val);
        send_item(CMD_WRITE_LONG, 16'($urandom), 16'($urandom), 2'($urandom), addr, val);
        items_sent++;
    endtask

    task automatic write_short(input logic [1:0] sel, input logic [17:0] addr,
                               input logic [15:0] val);
        send_item(CMD_WRITE_SHORT, 16'($urandom), 16'($urandom), sel, addr, val);
        items_sent++;
    endtask

    task automatic send_noise(input logic [2:0] cmd);
        send_item(cmd, 16'($urandom), 16'($urandom), 2'($urandom), 18'($urandom),
                  16'($urandom));
    endtask

    // Fill every store word the mix is about to read, then mix
    task automatic mix_frame(input logic [15:0] left, input logic [15:0] right);
        int         addr;
        logic [1:0] sel;
        while (sb.missing_long(addr))
            write_long(addr[17:0], rand_sample());
        while (sb.missing_short(sel, addr))
            write_short(sel, addr[17:0], rand_sample());
        send_item(CMD_MIX, left, right, 2'($urandom), 18'($urandom), 16'($urandom));
        items_sent++;
    endtask

    // Stop offering and let every outstanding item drain
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] index, input logic [23:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_reg(index, data);
    endtask

    task automatic configure(input logic [1:0] channels, input logic [23:0] lstep,
                             input logic [23:0] sstep, input logic [18:0] lframes,
                             input logic [14:0] s0, input logic [14:0] s1,
                             input logic [14:0] s2);
        write_reg(REG_LONG_CHANNELS, 24'(channels));
        write_reg(REG_LONG_STEP, lstep);
        write_reg(REG_SHORT_STEP, sstep);
        write_reg(REG_LONG_FRAMES, 24'(lframes));
        write_reg(REG_SHORT0_FRAMES, 24'(s0));
        write_reg(REG_SHORT1_FRAMES, 24'(s1));
        write_reg(REG_SHORT2_FRAMES, 24'(s2));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 24'h010000;
        if (r < 25)
            return 24'h000001;
        if (r < 35)
            return 24'hFFFFFF;
        if (r < 70)
            return 24'($urandom_range(1, 24'h030000));
        return 24'($urandom_range(1, 24'hFFFFFF));
    endfunction

    function automatic logic [14:0] pick_short_frames();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 15'd0;
        if (r < 15)
            return 15'd16384;
        if (r < 18)
            return 15'h7FFF;
        return 15'($urandom_range(1, 8));
    endfunction

    task automatic random_config();
        int          r;
        logic [1:0]  channels;
        logic [18:0] lframes;
        r = $urandom_range(99);
        channels = (r < 15) ? 2'd0 : (r < 30) ? 2'd3 : 2'($urandom_range(1, 2));
        r = $urandom_range(99);
        lframes = (r < 10) ? 19'd0 : (r < 15) ? 19'h7FFFF : (r < 20) ? 19'd262144 :
                  19'($urandom_range(1, 12));
        configure(channels, pick_step(), pick_step(), lframes,
                  pick_short_frames(), pick_short_frames(), pick_short_frames());
    endtask

    // Mostly start-then-mix sequences, with writes, bad selects and noise mixed in
    task automatic random_phase(input int count);
        int r;
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            r = $urandom_range(99);
            if (!sb.long_playing && r < 25)
                start_long();
            else if (!sb.short_playing && r < 50)
                start_short(2'($urandom_range(3)));
            else if (r < 4)
                start_long();
            else if (r < 8)
                start_short(2'($urandom_range(3)));
            else if (r < 12)
                write_long(18'($urandom_range(262143)), rand_sample());
            else if (r < 16)
                write_short(2'($urandom_range(3)),
                            18'(($urandom_range(99) < 20) ? $urandom_range(262143) :
                                                            $urandom_range(SHORT_WORDS - 1)),
                            rand_sample());
            else if (r < 19)
                send_noise(3'($urandom_range(5, 7)));
            else
                mix_frame(rand_sample(), rand_sample());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        hold_ask            <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_MIX;
        req_ch.in_left      <= '0;
        req_ch.in_right     <= '0;
        req_ch.clip_select  <= '0;
        req_ch.sample_addr  <= '0;
        req_ch.sample_value <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_LONG_CHANNELS;
        cfg_ch.data         <= '0;
        sender_may_idle = 1'b1;
        items_sent      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Starts on empty clips are dropped; the frame passes through
        start_long();
        start_short(2'd0);
        mix_frame(16'h7FFF, 16'h8000);
        wait_idle();

        // Two-frame clips, short voice at half rate
        configure(2'd2, 24'h010000, 24'h008000, 19'd2, 15'd2, 15'd1, 15'd16384);
        write_long(18'd0, 16'h7FFF);
        write_long(18'd1, 16'h8000);
        write_short(2'd0, 18'd0, 16'h7FFF);
        write_short(2'd0, 18'd1, 16'h8000);
        // bad clip index and out-of-range address are ignored
        start_short(2'd3);
        write_short(2'd3, 18'd0, rand_sample());
        write_short(2'd0, 18'h3FFFF, rand_sample());
        send_noise(3'd5);
        send_noise(3'd6);
        send_noise(3'd7);
        start_long();
        start_short(2'd0);
        // both rails saturate
        mix_frame(16'h7FFF, 16'h8000);
        // long voice ends on the third mix, short voice on the fifth
        repeat (4) mix_frame(rand_sample(), rand_sample());
        start_long();
        mix_frame(rand_sample(), rand_sample());
        wait_idle();
        // long voice made unusable while playing: it adds nothing and holds
        configure(2'd0, 24'h010000, 24'h008000, 19'd2, 15'd2, 15'd1, 15'd16384);
        mix_frame(rand_sample(), rand_sample());
        wait_idle();

        // Largest settings
        configure(2'd3, 24'hFFFFFF, 24'hFFFFFF, 19'h7FFFF, 15'h7FFF, 15'd16384, 15'd0);
        random_phase(60);
        wait_idle();

        // Smallest settings, mono long clip
        configure(2'd1, 24'h000001, 24'h000001, 19'd1, 15'd1, 15'd1, 15'd1);
        random_phase(60);
        wait_idle();

        // Sender never idles here
        random_config();
        sender_may_idle = 1'b0;
        random_phase(110);
        sender_may_idle = 1'b1;
        wait_idle();

        // Result side holds off while items keep coming
        random_config();
        hold_ask <= 1'b1;
        random_phase(110);
        wait_idle();

        // Sender pauses mid-run until every frame is back
        random_config();
        random_phase(40);
        wait_idle();
        random_phase(40);
        wait_idle();

        // Fastest step on the longest short clip: reads run past the short store
        configure(2'd2, 24'hFFFFFF, 24'hFFFFFF, 19'd0, 15'h7FFF, 15'd1, 15'd16384);
        start_short(2'd0);
        repeat (FAR_MIXES)
        begin
            if (!sb.short_playing)
                start_short(2'd0);
            mix_frame(rand_sample(), rand_sample());
        end
        wait_idle();

        repeat (2)
        begin
            random_config();
            random_phase(40);
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
